// File: design/oadf_pkg.sv
`default_nettype none

package oadf_pkg;

    localparam int SAMPLE_W = 14;
    localparam int SUM_W    = 17;
    localparam int COUNT_W  = 3;
    localparam int MODE_W   = 3;
    localparam int CLASS_W  = 3;
    localparam int SPEED_W  = 7;
    localparam int COLOR_W  = 3;
    localparam int REG_IDX_W = 2;

    // drive modes
    localparam logic [MODE_W-1:0] MODE_ROTATE_LEFT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_VEER_LEFT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FORWARD      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_VEER_RIGHT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROTATE_RIGHT = 3'd4;

    // obstacle classes
    localparam logic [CLASS_W-1:0] CLASS_LEFT         = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_CENTER_LEFT  = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_CENTER       = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_CENTER_RIGHT = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_RIGHT        = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_NONE         = 3'd5;

    // status colors (bit0 red, bit1 green, bit2 blue)
    localparam logic [COLOR_W-1:0] COLOR_RED    = 3'h1;
    localparam logic [COLOR_W-1:0] COLOR_GREEN  = 3'h2;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'h3;
    localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'h4;
    localparam logic [COLOR_W-1:0] COLOR_PURPLE = 3'h5;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_NEAR_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FAST_SPEED     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SLOW_SPEED     = 2'd2;

    localparam logic [SAMPLE_W-1:0] NEAR_THRESHOLD_RST = 14'd6000;
    localparam logic [SPEED_W-1:0]  FAST_SPEED_RST     = 7'd50;
    localparam logic [SPEED_W-1:0]  SLOW_SPEED_RST     = 7'd20;

    typedef struct packed {
        logic [SAMPLE_W-1:0] near_threshold;
        logic [SPEED_W-1:0]  fast_speed;
        logic [SPEED_W-1:0]  slow_speed;
    } cfg_t;

    typedef struct packed {
        logic right;
        logic center;
        logic left;
    } near_t;

    typedef struct packed {
        logic               left_fast;
        logic               left_forward;
        logic               right_fast;
        logic               right_forward;
        logic [COLOR_W-1:0] color;
    } drive_t;

    typedef struct packed {
        logic [MODE_W-1:0]  drive_mode;
        logic [CLASS_W-1:0] obstacle_class;
        logic [SPEED_W-1:0] left_duty;
        logic               left_forward;
        logic [SPEED_W-1:0] right_duty;
        logic               right_forward;
        logic [COLOR_W-1:0] led_color;
    } result_t;

    // center first, right before left
    function automatic logic [CLASS_W-1:0] classify(input near_t n);
        logic [CLASS_W-1:0] c;
        if (n.center)
        begin
            if (n.right)
                c = n.left ? CLASS_CENTER : CLASS_CENTER_RIGHT;
            else
                c = n.left ? CLASS_CENTER_LEFT : CLASS_CENTER;
        end
        else if (n.right)
            c = CLASS_RIGHT;
        else if (n.left)
            c = CLASS_LEFT;
        else
            c = CLASS_NONE;
        return c;
    endfunction

    // mode transition table; out-of-range modes use the forward row
    function automatic logic [MODE_W-1:0] next_mode(input logic [MODE_W-1:0] m,
                                                    input logic [CLASS_W-1:0] c);
        logic [MODE_W-1:0] r;
        if (c == CLASS_NONE)
            r = MODE_FORWARD;
        else
        begin
            unique case (m)
                MODE_ROTATE_LEFT:  r = MODE_ROTATE_LEFT;
                MODE_ROTATE_RIGHT: r = MODE_ROTATE_RIGHT;
                MODE_VEER_LEFT:
                begin
                    unique case (c)
                        CLASS_LEFT:         r = MODE_VEER_RIGHT;
                        CLASS_CENTER_LEFT:  r = MODE_ROTATE_RIGHT;
                        CLASS_CENTER:       r = MODE_ROTATE_LEFT;
                        CLASS_CENTER_RIGHT: r = MODE_ROTATE_LEFT;
                        CLASS_RIGHT:        r = MODE_VEER_LEFT;
                        default:            r = MODE_FORWARD;
                    endcase
                end
                default:
                begin
                    unique case (c)
                        CLASS_LEFT:         r = MODE_VEER_RIGHT;
                        CLASS_CENTER_LEFT:  r = MODE_ROTATE_RIGHT;
                        CLASS_CENTER:       r = MODE_ROTATE_RIGHT;
                        CLASS_CENTER_RIGHT: r = MODE_ROTATE_LEFT;
                        CLASS_RIGHT:        r = MODE_VEER_LEFT;
                        default:            r = MODE_FORWARD;
                    endcase
                end
            endcase
        end
        return r;
    endfunction

    function automatic drive_t drive_row(input logic [MODE_W-1:0] m);
        drive_t d;
        unique case (m)
            MODE_ROTATE_LEFT:  d = '{1'b0, 1'b0, 1'b0, 1'b1, COLOR_PURPLE};
            MODE_VEER_LEFT:    d = '{1'b0, 1'b1, 1'b1, 1'b1, COLOR_BLUE};
            MODE_VEER_RIGHT:   d = '{1'b1, 1'b1, 1'b0, 1'b1, COLOR_GREEN};
            MODE_ROTATE_RIGHT: d = '{1'b1, 1'b1, 1'b0, 1'b0, COLOR_YELLOW};
            default:           d = '{1'b1, 1'b1, 1'b1, 1'b1, COLOR_RED};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: design/oadf_if.sv
`default_nettype none

interface oadf_in_if;
    logic                          valid;
    logic                          ready;
    logic [oadf_pkg::SAMPLE_W-1:0] right_sample;
    logic [oadf_pkg::SAMPLE_W-1:0] center_sample;
    logic [oadf_pkg::SAMPLE_W-1:0] left_sample;

    modport source (output valid, output right_sample, output center_sample,
                    output left_sample, input ready);
    modport sink (input valid, input right_sample, input center_sample,
                  input left_sample, output ready);
endinterface

interface oadf_out_if;
    logic                         valid;
    logic                         ready;
    logic [oadf_pkg::MODE_W-1:0]  drive_mode;
    logic [oadf_pkg::CLASS_W-1:0] obstacle_class;
    logic [oadf_pkg::SPEED_W-1:0] left_duty;
    logic                         left_forward;
    logic [oadf_pkg::SPEED_W-1:0] right_duty;
    logic                         right_forward;
    logic [oadf_pkg::COLOR_W-1:0] led_color;

    modport source (output valid, output drive_mode, output obstacle_class,
                    output left_duty, output left_forward, output right_duty,
                    output right_forward, output led_color, input ready);
    modport sink (input valid, input drive_mode, input obstacle_class,
                  input left_duty, input left_forward, input right_duty,
                  input right_forward, input led_color, output ready);
endinterface

`default_nettype wire

// File: design/oadf_cfg.sv
`default_nettype none

module oadf_cfg
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output oadf_pkg::cfg_t           cfg
);

    oadf_pkg::cfg_t                      cfg_reg;
    logic                                wr_en;
    logic [oadf_pkg::REG_IDX_W-1:0]      idx;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold <= oadf_pkg::NEAR_THRESHOLD_RST;
            cfg_reg.fast_speed     <= oadf_pkg::FAST_SPEED_RST;
            cfg_reg.slow_speed     <= oadf_pkg::SLOW_SPEED_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                oadf_pkg::REG_NEAR_THRESHOLD:
                    cfg_reg.near_threshold <= pwdata[oadf_pkg::SAMPLE_W-1:0];
                oadf_pkg::REG_FAST_SPEED:
                    cfg_reg.fast_speed <= pwdata[oadf_pkg::SPEED_W-1:0];
                oadf_pkg::REG_SLOW_SPEED:
                    cfg_reg.slow_speed <= pwdata[oadf_pkg::SPEED_W-1:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            oadf_pkg::REG_NEAR_THRESHOLD:
                prdata = 32'(cfg_reg.near_threshold);
            oadf_pkg::REG_FAST_SPEED:
                prdata = 32'(cfg_reg.fast_speed);
            oadf_pkg::REG_SLOW_SPEED:
                prdata = 32'(cfg_reg.slow_speed);
            default:
                prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/oadf_lane.sv
`default_nettype none

module oadf_lane
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          last,
    input  wire logic [oadf_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [oadf_pkg::SUM_W-1:0]    thr_scaled,
    output logic                               near
);

    localparam int SumW = oadf_pkg::SUM_W;

    logic [SumW-1:0] sum_reg;
    logic [SumW-1:0] sum_next;
    logic            near_reg;

    // floor(sum/N) >= thr  <=>  sum >= thr*N
    assign sum_next = sum_reg + SumW'(sample);
    assign near     = near_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (accept)
            sum_reg <= last ? '0 : sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
            near_reg <= (sum_next >= thr_scaled);
    end

endmodule

`default_nettype wire

// File: design/oadf_merge.sv
`default_nettype none

module oadf_merge
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s1_valid,
    input  wire oadf_pkg::near_t near,
    input  wire oadf_pkg::cfg_t  cfg,
    output logic                take_ready,
    oadf_out_if.source          drive
);

    logic [oadf_pkg::MODE_W-1:0]  mode_reg;
    logic [oadf_pkg::MODE_W-1:0]  mode_mid;
    logic [oadf_pkg::MODE_W-1:0]  mode_next;
    logic [oadf_pkg::CLASS_W-1:0] cls;
    oadf_pkg::drive_t             row;
    oadf_pkg::result_t            res_reg;
    oadf_pkg::result_t            res_next;
    logic                         out_valid_reg;
    logic                         take;

    assign take_ready = !out_valid_reg || drive.ready;
    assign take       = s1_valid && take_ready;

    // table applied twice: the settled mode for this class
    always_comb
    begin
        cls       = oadf_pkg::classify(near);
        mode_mid  = oadf_pkg::next_mode(mode_reg, cls);
        mode_next = oadf_pkg::next_mode(mode_mid, cls);
        row       = oadf_pkg::drive_row(mode_next);

        res_next.drive_mode     = mode_next;
        res_next.obstacle_class = cls;
        res_next.left_duty      = row.left_fast ? cfg.fast_speed : cfg.slow_speed;
        res_next.left_forward   = row.left_forward;
        res_next.right_duty     = row.right_fast ? cfg.fast_speed : cfg.slow_speed;
        res_next.right_forward  = row.right_forward;
        res_next.led_color      = row.color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= oadf_pkg::MODE_FORWARD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg      <= mode_next;
                out_valid_reg <= 1'b1;
            end
            else if (drive.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign drive.valid          = out_valid_reg;
    assign drive.drive_mode     = res_reg.drive_mode;
    assign drive.obstacle_class = res_reg.obstacle_class;
    assign drive.left_duty      = res_reg.left_duty;
    assign drive.left_forward   = res_reg.left_forward;
    assign drive.right_duty     = res_reg.right_duty;
    assign drive.right_forward  = res_reg.right_forward;
    assign drive.led_color      = res_reg.led_color;

endmodule

`default_nettype wire

// File: design/obstacle_avoid_drive_fsm_top.sv
`default_nettype none

// Obstacle-avoiding drive controller. Each sensor transaction carries one
// right/center/left triple of 14-bit samples; every SAMPLES_PER_AVERAGE
// transactions close a group and yield one drive transaction (mode, obstacle
// class, motor speeds and directions, status color), other transactions
// yield nothing. A transaction is taken every cycle: the sensor side only
// stalls when a group-closing sample arrives while both the near-flag stage
// and the output register are full and the output is stalled. The result
// of a group reaches the drive side through two register stages, first the
// near flags in the three channel lanes, then the merge stage's output
// register, and it is held there so new samples keep flowing while it
// waits. Each lane does one 17-bit add and compare per cycle in which a
// sample is accepted: instead of dividing the sum it compares against
// near_threshold * SAMPLES_PER_AVERAGE, which gives the same
// truncated-average decision. Registers (APB, byte address 4*i):
// 0 near_threshold (reset 6000), 1 fast_speed (50), 2 slow_speed (20).
// Change them only while no group is in flight.

module obstacle_avoid_drive_fsm_top
#(
    parameter int SAMPLES_PER_AVERAGE = 3   // 1..8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    oadf_in_if.sink          sensor,
    oadf_out_if.source       drive
);

    localparam int SumW   = oadf_pkg::SUM_W;
    localparam int CountW = oadf_pkg::COUNT_W;
    localparam logic [CountW-1:0] LastCount = CountW'(SAMPLES_PER_AVERAGE - 1);

    oadf_pkg::cfg_t    cfg;
    oadf_pkg::near_t   near;
    logic [SumW-1:0]   thr_scaled;
    logic [CountW-1:0] count_reg;
    logic              s1_valid_reg;
    logic              merge_ready;
    logic              s1_free;
    logic              last;
    logic              accept;

    oadf_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // threshold scaled to the group sum (fits 17 bits for N up to 8)
    assign thr_scaled = SumW'(cfg.near_threshold) * SumW'(SAMPLES_PER_AVERAGE);

    // group bookkeeping
    assign last         = (count_reg == LastCount);
    assign s1_free      = !s1_valid_reg || merge_ready;
    assign sensor.ready = !last || s1_free;
    assign accept       = sensor.valid && sensor.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= last ? '0 : count_reg + CountW'(1);

            if (accept && last)
                s1_valid_reg <= 1'b1;
            else if (merge_ready)
                s1_valid_reg <= 1'b0;
        end
    end

    // one lane per sensor channel
    oadf_lane u_lane_right
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .last       (last),
        .sample     (sensor.right_sample),
        .thr_scaled (thr_scaled),
        .near       (near.right)
    );

    oadf_lane u_lane_center
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .last       (last),
        .sample     (sensor.center_sample),
        .thr_scaled (thr_scaled),
        .near       (near.center)
    );

    oadf_lane u_lane_left
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .last       (last),
        .sample     (sensor.left_sample),
        .thr_scaled (thr_scaled),
        .near       (near.left)
    );

    // classify, settle the mode, look up the drive row, hold the result
    oadf_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .near       (near),
        .cfg        (cfg),
        .take_ready (merge_ready),
        .drive      (drive)
    );

endmodule

`default_nettype wire

// File: tb/obstacle_avoid_drive_fsm_top_test.sv
`timescale 1ns / 1ps

module obstacle_avoid_drive_fsm_top_test;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int GROUP        = 3;       // triples per averaged group
    localparam int SAMPLE_MAX   = 16383;
    localparam int SUM_MAX      = GROUP * SAMPLE_MAX;
    localparam int RANDOM_GROUPS = 87;     // per register setting
    localparam int HOLD_AT      = 40;      // drive transactions before the long stall
    localparam int HOLD_CYCLES  = 300;     // long receiver stall, fills the pipe
    localparam int STALL_LIMIT  = 3000;    // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 8;       // margin after both queues empty, before the registers change

    // register index with no register behind it; writes must be dropped
    localparam logic [oadf_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [oadf_pkg::SAMPLE_W-1:0] right;
        logic [oadf_pkg::SAMPLE_W-1:0] center;
        logic [oadf_pkg::SAMPLE_W-1:0] left;
    } triple_t;

    // ------------------------------------------------------------------
    // Clock, reset, ports
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    always #5 clk = ~clk;

    oadf_in_if  sensor_if ();
    oadf_out_if drive_if ();

    obstacle_avoid_drive_fsm_top #(.SAMPLES_PER_AVERAGE(GROUP)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sensor  (sensor_if),
        .drive   (drive_if)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    triple_t             sample_queue[$];      // triples not yet taken by the block
    oadf_pkg::result_t   expected_drive[$];    // predicted drive transactions, oldest first

    // register shadow, follows every APB write
    logic [oadf_pkg::SAMPLE_W-1:0] near_thr = oadf_pkg::NEAR_THRESHOLD_RST;
    logic [oadf_pkg::SPEED_W-1:0]  fast_spd = oadf_pkg::FAST_SPEED_RST;
    logic [oadf_pkg::SPEED_W-1:0]  slow_spd = oadf_pkg::SLOW_SPEED_RST;

    // predictor state: running sums, group fill, current mode
    logic [oadf_pkg::SUM_W-1:0]    right_acc  = '0;
    logic [oadf_pkg::SUM_W-1:0]    center_acc = '0;
    logic [oadf_pkg::SUM_W-1:0]    left_acc   = '0;
    logic [oadf_pkg::COUNT_W-1:0]  group_fill = '0;
    logic [oadf_pkg::MODE_W-1:0]   mode_now   = oadf_pkg::MODE_FORWARD;

    bit   idle_on   = 1'b1;          // random gaps on both sides
    logic in_fire   = 1'b0;          // sensor transaction at the last rising edge
    int   src_gap   = 0;
    int   snk_gap   = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    int   mismatches  = 0;
    int   items_taken = 0;
    int   results_seen = 0;
    int   reg_writes  = 0;
    logic [5:0] class_seen = '0;
    logic [4:0] mode_seen  = '0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // center decides first; with center near, right is checked before left
    function automatic logic [oadf_pkg::CLASS_W-1:0] classify_near(input logic r,
                                                                   input logic c,
                                                                   input logic l);
        if (c)
            return r ? (l ? oadf_pkg::CLASS_CENTER : oadf_pkg::CLASS_CENTER_RIGHT)
                     : (l ? oadf_pkg::CLASS_CENTER_LEFT : oadf_pkg::CLASS_CENTER);
        if (r)
            return oadf_pkg::CLASS_RIGHT;
        if (l)
            return oadf_pkg::CLASS_LEFT;
        return oadf_pkg::CLASS_NONE;
    endfunction

    // one step of the mode table, organized by class: a clear path always
    // goes forward, the rotate modes keep rotating while anything is near
    function automatic logic [oadf_pkg::MODE_W-1:0] steer_next(
        input logic [oadf_pkg::MODE_W-1:0] m,
        input logic [oadf_pkg::CLASS_W-1:0] cls);
        if (cls == oadf_pkg::CLASS_NONE)
            return oadf_pkg::MODE_FORWARD;
        if (m == oadf_pkg::MODE_ROTATE_LEFT || m == oadf_pkg::MODE_ROTATE_RIGHT)
            return m;
        case (cls)
            oadf_pkg::CLASS_LEFT:         return oadf_pkg::MODE_VEER_RIGHT;
            oadf_pkg::CLASS_CENTER_LEFT:  return oadf_pkg::MODE_ROTATE_RIGHT;
            oadf_pkg::CLASS_CENTER:
                return (m == oadf_pkg::MODE_VEER_LEFT) ? oadf_pkg::MODE_ROTATE_LEFT
                                                       : oadf_pkg::MODE_ROTATE_RIGHT;
            oadf_pkg::CLASS_CENTER_RIGHT: return oadf_pkg::MODE_ROTATE_LEFT;
            default:                      return oadf_pkg::MODE_VEER_LEFT;
        endcase
    endfunction

    // motor speeds, directions and color for a mode, at the current speeds
    function automatic oadf_pkg::result_t drive_for(input logic [oadf_pkg::MODE_W-1:0] m);
        oadf_pkg::result_t d;
        d = '0;
        d.drive_mode = m;
        case (m)
            oadf_pkg::MODE_ROTATE_LEFT:
            begin
                d.left_duty = slow_spd;  d.left_forward = 1'b0;
                d.right_duty = slow_spd; d.right_forward = 1'b1;
                d.led_color = oadf_pkg::COLOR_PURPLE;
            end
            oadf_pkg::MODE_VEER_LEFT:
            begin
                d.left_duty = slow_spd;  d.left_forward = 1'b1;
                d.right_duty = fast_spd; d.right_forward = 1'b1;
                d.led_color = oadf_pkg::COLOR_BLUE;
            end
            oadf_pkg::MODE_VEER_RIGHT:
            begin
                d.left_duty = fast_spd;  d.left_forward = 1'b1;
                d.right_duty = slow_spd; d.right_forward = 1'b1;
                d.led_color = oadf_pkg::COLOR_GREEN;
            end
            oadf_pkg::MODE_ROTATE_RIGHT:
            begin
                d.left_duty = fast_spd;  d.left_forward = 1'b1;
                d.right_duty = slow_spd; d.right_forward = 1'b0;
                d.led_color = oadf_pkg::COLOR_YELLOW;
            end
            default:
            begin
                d.left_duty = fast_spd;  d.left_forward = 1'b1;
                d.right_duty = fast_spd; d.right_forward = 1'b1;
                d.led_color = oadf_pkg::COLOR_RED;
            end
        endcase
        return d;
    endfunction

    // accumulate one accepted triple; a closing triple yields one expectation
    task automatic absorb_triple(input triple_t t);
        logic [oadf_pkg::CLASS_W-1:0] cls;
        logic [oadf_pkg::MODE_W-1:0]  m;
        oadf_pkg::result_t            res;
        right_acc  = right_acc + oadf_pkg::SUM_W'(t.right);
        center_acc = center_acc + oadf_pkg::SUM_W'(t.center);
        left_acc   = left_acc + oadf_pkg::SUM_W'(t.left);
        group_fill = group_fill + oadf_pkg::COUNT_W'(1);
        if (int'(group_fill) < GROUP)
            return;
        cls = classify_near((int'(right_acc) / GROUP) >= int'(near_thr),
                            (int'(center_acc) / GROUP) >= int'(near_thr),
                            (int'(left_acc) / GROUP) >= int'(near_thr));
        right_acc  = '0;
        center_acc = '0;
        left_acc   = '0;
        group_fill = '0;
        // the table is applied twice per group
        m = steer_next(steer_next(mode_now, cls), cls);
        mode_now = m;
        res = drive_for(m);
        res.obstacle_class = cls;
        expected_drive.push_back(res);
        class_seen[cls] = 1'b1;
        mode_seen[m] = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // break a channel's group sum into GROUP samples, each in range
    task automatic split_sum(input int total, output logic [oadf_pkg::SAMPLE_W-1:0] a,
                             output logic [oadf_pkg::SAMPLE_W-1:0] b,
                             output logic [oadf_pkg::SAMPLE_W-1:0] c);
        int lo, hi, rest, av, bv, cv;
        lo = (total > 2 * SAMPLE_MAX) ? total - 2 * SAMPLE_MAX : 0;
        hi = (total < SAMPLE_MAX) ? total : SAMPLE_MAX;
        av = $urandom_range(hi, lo);
        rest = total - av;
        lo = (rest > SAMPLE_MAX) ? rest - SAMPLE_MAX : 0;
        hi = (rest < SAMPLE_MAX) ? rest : SAMPLE_MAX;
        bv = $urandom_range(hi, lo);
        cv = rest - bv;
        a = av[oadf_pkg::SAMPLE_W-1:0];
        b = bv[oadf_pkg::SAMPLE_W-1:0];
        c = cv[oadf_pkg::SAMPLE_W-1:0];
    endtask

    // queue one whole group given the per-channel sums (right, center, left)
    task automatic queue_group(input int r_total, input int c_total, input int l_total);
        logic [oadf_pkg::SAMPLE_W-1:0] r[3], c[3], l[3];
        triple_t                       t;
        split_sum(r_total, r[0], r[1], r[2]);
        split_sum(c_total, c[0], c[1], c[2]);
        split_sum(l_total, l[0], l[1], l[2]);
        for (int i = 0; i < GROUP; i++)
        begin
            t.right  = r[i];
            t.center = c[i];
            t.left   = l[i];
            sample_queue.push_back(t);
        end
    endtask

    // channel sum biased around the current threshold: near, far, right on
    // the edge of the decision, or anywhere
    function automatic int pick_sum();
        int span, k;
        span = GROUP * int'(near_thr);
        k = $urandom_range(9, 0);
        if (k >= 4 && k <= 8 && span == 0)
            k = 0;                      // nothing can be far at threshold zero
        if (k <= 3)
            return $urandom_range(SUM_MAX, span);
        if (k <= 7)
            return $urandom_range(span - 1, 0);
        if (k == 8)
            return $urandom_range(1, 0) ? span : span - 1;
        return $urandom_range(SUM_MAX, 0);
    endfunction

    task automatic queue_random_groups(input int n);
        repeat (n)
            queue_group(pick_sum(), pick_sum(), pick_sum());
    endtask

    // APB write: setup then access; the shadow follows what the block keeps
    task automatic program_reg(input logic [oadf_pkg::REG_IDX_W-1:0] idx,
                               input logic [31:0] value, input bit junk);
        logic [31:0] mask, data;
        mask = (idx == oadf_pkg::REG_NEAR_THRESHOLD) ? 32'h3FFF : 32'h7F;
        data = junk ? ((value & mask) | ($urandom() & ~mask)) : value;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            oadf_pkg::REG_NEAR_THRESHOLD: near_thr = data[oadf_pkg::SAMPLE_W-1:0];
            oadf_pkg::REG_FAST_SPEED:     fast_spd = data[oadf_pkg::SPEED_W-1:0];
            oadf_pkg::REG_SLOW_SPEED:     slow_spd = data[oadf_pkg::SPEED_W-1:0];
            default:                      ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_setting(input int thr, input int fast, input int slow, input bit junk);
        program_reg(oadf_pkg::REG_NEAR_THRESHOLD, thr, junk);
        program_reg(oadf_pkg::REG_FAST_SPEED, fast, junk);
        program_reg(oadf_pkg::REG_SLOW_SPEED, slow, junk);
    endtask

    // all triples taken and all drive transactions back, then a margin so
    // nothing is still in flight when the registers change
    task automatic settle_block();
        while (sample_queue.size() != 0 || expected_drive.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sensor side: driver at the falling edge, acceptance at the rising edge
    // ------------------------------------------------------------------

    // A triple offered stays on the bus until taken. Gaps only start
    // between transactions.
    always @(negedge clk)
    begin : sensor_driver
        logic offer;
        if (!(sensor_if.valid === 1'b1 && !in_fire))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                offer = 1'b0;
            end
            else if (sample_queue.size() == 0)
                offer = 1'b0;
            else if (idle_on && $urandom_range(7, 0) == 0)
            begin
                src_gap = $urandom_range(10, 1) - 1;
                offer = 1'b0;
            end
            else
                offer = 1'b1;
            sensor_if.valid <= offer;
            if (offer)
            begin
                sensor_if.right_sample  <= sample_queue[0].right;
                sensor_if.center_sample <= sample_queue[0].center;
                sensor_if.left_sample   <= sample_queue[0].left;
            end
        end
    end

    always @(posedge clk)
    begin : sensor_monitor
        in_fire <= rst_n && sensor_if.valid === 1'b1 && sensor_if.ready === 1'b1;
        if (rst_n && sensor_if.valid === 1'b1 && sensor_if.ready === 1'b1)
        begin
            absorb_triple(sample_queue.pop_front());
            items_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Drive side: ready at the falling edge, checking at the rising edge
    // ------------------------------------------------------------------

    // Once, after HOLD_AT drive transactions, ready stays low for a long
    // stretch while triples keep coming, so the output register and the
    // near-flag stage fill and the sensor side must stall.
    always @(negedge clk)
    begin : drive_ready_gen
        logic rdy;
        if (!rst_n)
            rdy = 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rdy = 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap--;
            rdy = 1'b0;
        end
        else if (idle_on && $urandom_range(7, 0) == 0)
        begin
            snk_gap = $urandom_range(10, 1) - 1;
            rdy = 1'b0;
        end
        else
            rdy = 1'b1;
        drive_if.ready <= rdy;
    end

    always @(posedge clk)
    begin : drive_monitor
        oadf_pkg::result_t want;
        if (rst_n && drive_if.valid === 1'b1 && drive_if.ready === 1'b1)
        begin
            if (expected_drive.size() == 0)
            begin
                $error("drive transaction with none expected: mode %0d class %0d",
                       drive_if.drive_mode, drive_if.obstacle_class);
                mismatches++;
            end
            else
            begin
                want = expected_drive.pop_front();
                check_field("drive_mode", 32'(want.drive_mode), 32'(drive_if.drive_mode));
                check_field("obstacle_class", 32'(want.obstacle_class),
                            32'(drive_if.obstacle_class));
                check_field("left_duty", 32'(want.left_duty), 32'(drive_if.left_duty));
                check_field("left_forward", 32'(want.left_forward),
                            32'(drive_if.left_forward));
                check_field("right_duty", 32'(want.right_duty), 32'(drive_if.right_duty));
                check_field("right_forward", 32'(want.right_forward),
                            32'(drive_if.right_forward));
                check_field("led_color", 32'(want.led_color), 32'(drive_if.led_color));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction on either channel
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sensor_if.valid === 1'b1 && sensor_if.ready === 1'b1) ||
                (drive_if.valid === 1'b1 && drive_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transaction for %0d cycles, %0d triples and %0d drive results pending",
               STALL_LIMIT, sample_queue.size(), expected_drive.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed groups, then random groups under a series
    // of register settings. Every phase is a whole number of groups so no
    // partial sum spans a register change.
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int near_sum, far_sum;
        near_sum = 30000;               // average 10000, near at reset threshold
        far_sum  = 3000;                // average 1000, far

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sensor_if.valid         = 1'b0;
        sensor_if.right_sample  = '0;
        sensor_if.center_sample = '0;
        sensor_if.left_sample   = '0;
        drive_if.ready          = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed, at reset settings (threshold 6000). Mode walk:
        // forward -> veer right -> rotate right -> forward -> veer left
        // -> rotate left, with center seen from veer left.
        queue_group(0, 0, 0);                        // all zero, clear path
        queue_group(far_sum, far_sum, near_sum);     // left only
        queue_group(far_sum, near_sum, near_sum);    // center-left
        queue_group(far_sum, far_sum, far_sum);      // back to forward
        queue_group(near_sum, far_sum, far_sum);     // right only
        queue_group(far_sum, near_sum, far_sum);     // center from veer left
        queue_group(SUM_MAX, SUM_MAX, SUM_MAX);      // all full scale: counts as center
        // right exactly at threshold, center one above, left one below:
        // center and right near gives center-right
        queue_group(GROUP * 6000, GROUP * 6000 + 1, GROUP * 6000 - 1);
        queue_random_groups(RANDOM_GROUPS);
        settle_block();

        // threshold zero: every channel near; speed extremes
        apply_setting(0, 100, 0, 1'b0);
        program_reg(REG_SPARE, $urandom(), 1'b1);    // must be ignored
        queue_random_groups(RANDOM_GROUPS);
        settle_block();

        // top threshold, speeds above one hundred pass through unclamped
        apply_setting(SAMPLE_MAX, 127, 101, 1'b0);
        queue_random_groups(RANDOM_GROUPS);
        settle_block();

        apply_setting(1, 0, 100, 1'b0);
        queue_random_groups(RANDOM_GROUPS);
        settle_block();

        // random settings, with garbage above each register's width
        repeat (2)
        begin
            apply_setting($urandom_range(SAMPLE_MAX, 0), $urandom_range(127, 0),
                          $urandom_range(127, 0), 1'b1);
            queue_random_groups(RANDOM_GROUPS);
            settle_block();
        end

        // last stretch at full rate on both sides
        idle_on = 1'b0;
        apply_setting($urandom_range(12000, 2000), 50, 20, 1'b0);
        queue_random_groups(RANDOM_GROUPS);
        settle_block();
        repeat (20) @(negedge clk);

        $display("Covered %0d sensor transactions, %0d drive results, %0d register writes.",
                 items_taken, results_seen, reg_writes);
        $display("Obstacle classes seen %b, drive modes seen %b (bit per code).",
                 class_seen, mode_seen);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
